// ===== rtl/core/txp_pkg.sv =====
package txp_pkg;

    // Entry layout (byte positions within one 20-byte entry)
    localparam int ENTRY_BYTES    = 20;
    localparam int OFFSET_DIGITS  = 10;
    localparam int GEN_FIRST      = 11;
    localparam int GEN_END        = 16;
    localparam int USED_POS       = 17;
    localparam int POS_W          = 5;

    localparam int ID_BITS_DEF    = 24;

    // Field widths of the stream words
    localparam int CHAR_W         = 8;
    localparam int START_ID_W     = 24;
    localparam int OBJ_ID_W       = 24;
    localparam int OFFSET_W       = 34;
    localparam int GEN_W          = 17;
    localparam int DIGIT_W        = 4;

    localparam logic [GEN_W-1:0]  GEN_BOGUS = GEN_W'(65536);
    localparam logic [CHAR_W-1:0] CHAR_USED = 8'h6E;   // 'n'
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;   // '0'
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;   // '9'

    // Result kinds
    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_PATCH = 1'b1;

    // Result queue
    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_W      = 2;
    localparam int RES_CNT_W      = 3;
    localparam int PUSH_W         = 2;

    typedef struct packed {
        logic                 kind;
        logic [OBJ_ID_W-1:0]  object_id;
        logic [OFFSET_W-1:0]  entry_offset;
        logic [GEN_W-1:0]     gen_or_link;
        logic                 in_use;
        logic                 last;
    } result_t;

endpackage

// ===== rtl/core/txp_res_fifo.sv =====
module txp_res_fifo
    import txp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PUSH_W-1:0] push_cnt,   // 0, 1 or 2 results this cycle
    input  result_t           din0,
    input  result_t           din1,
    output logic              room2,      // at least two free slots
    output logic              dout_valid,
    input  logic              dout_ready,
    output result_t           dout
);

    result_t                mem [RES_FIFO_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0]   count_reg, count_next;
    logic                   pop;

    assign dout_valid = (count_reg != '0);
    assign dout       = mem[rd_ptr_reg];
    assign pop        = dout_valid && dout_ready;
    assign room2      = (count_reg <= RES_CNT_W'(RES_FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != '0)
        begin
            mem[wr_ptr_reg] <= din0;
        end
        if (push_cnt == PUSH_W'(2))
        begin
            mem[wr_ptr_reg + RES_PTR_W'(1)] <= din1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RES_CNT_W'(RES_FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != '0) |-> (count_reg <= RES_CNT_W'(RES_FIFO_DEPTH) - RES_CNT_W'(push_cnt)))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg) + RES_CNT_W'($past(push_cnt))
                  - RES_CNT_W'($past(pop))))
        else $error("result queue count mismatch");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[RES_PTR_W-1:0])
        else $error("result queue pointers disagree with count");

endmodule

// ===== rtl/core/text_xref_entry_parser_unit.sv =====
// Text cross-reference entry parser. Bytes of a text xref table enter on the
// slave stream, one word per cycle, with tuser marking the first byte of a
// subsection (tdata[31:8] then carries the subsection's first object number).
// Each 20-byte entry is parsed as it streams: bytes 0-9 form the offset,
// bytes 11-15 the generation, byte 17 the 'n'/'f' mark; non-digits in digit
// positions count as zero. On the last byte of an entry the block queues an
// entry record (tuser = 0), and for a free entry that follows another free
// entry of the same subsection a patch word (tuser = 1) that links the older
// free entry to the new one; tlast marks the final word caused by a byte.
// Rate: one byte per cycle while tready is high. The per-byte multiply-add
// by ten and the in-use check are combinational; the results are written,
// registered, into the result queue on the entry's last byte. Results go via a
// 4-deep queue, and tready drops only while fewer than two queue slots are
// free, so a stalled master side holds the input off only once more than two
// results pile up. A subsection start mid-entry discards the partial entry.
module text_xref_entry_parser_unit
    import txp_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side: tdata = char_in[7:0], start_id[31:8]; tuser = sub_start
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    // master side: tdata = object_id[23:0], entry_offset[57:24],
    //              gen_or_link[74:58], in_use[75], zero fill; tuser = kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [GEN_W-1:0]    gen_reg, gen_next;
    logic                used_reg, used_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic                pfv_reg, pfv_next;
    logic [ID_BITS-1:0]  pfid_reg, pfid_next;

    logic                accept;
    logic [CHAR_W-1:0]   char_in;
    logic                sub_start;
    logic [START_ID_W-1:0] start_id;
    logic [DIGIT_W-1:0]  digit;

    // values after the subsection reset, then after this byte's field update
    logic [POS_W-1:0]    pos_b;
    logic [OFFSET_W-1:0] off_b, off_u;
    logic [GEN_W-1:0]    gen_b, gen_u;
    logic                used_b, used_u;
    logic [ID_BITS-1:0]  id_b;
    logic                pfv_b;
    logic                emit, in_use;

    logic [ID_BITS+START_ID_W-1:0] start_ext;
    logic [ID_BITS+OBJ_ID_W-1:0]   id_ext, pfid_ext;
    logic [ID_BITS+GEN_W-1:0]      link_ext;

    logic [PUSH_W-1:0]   push_cnt;
    result_t             res0, res1, res_out;
    logic                room2;

    assign char_in   = s_tdata[CHAR_W-1:0];
    assign start_id  = s_tdata[CHAR_W+START_ID_W-1:CHAR_W];
    assign sub_start = s_tuser;
    assign s_tready  = room2;
    assign accept    = s_tvalid && s_tready;

    assign digit = ((char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE))
                 ? DIGIT_W'(char_in - CHAR_ZERO) : '0;

    // zero-extended copies so any ID_BITS maps onto the fixed field widths
    assign start_ext = {{ID_BITS{1'b0}}, start_id};
    assign id_ext    = {{OBJ_ID_W{1'b0}}, id_b};
    assign pfid_ext  = {{OBJ_ID_W{1'b0}}, pfid_reg};
    assign link_ext  = {{GEN_W{1'b0}}, id_b};

    always_comb
    begin
        pos_b  = sub_start ? '0 : pos_reg;
        off_b  = sub_start ? '0 : off_reg;
        gen_b  = sub_start ? '0 : gen_reg;
        used_b = sub_start ? 1'b0 : used_reg;
        id_b   = sub_start ? start_ext[ID_BITS-1:0] : id_reg;
        pfv_b  = sub_start ? 1'b0 : pfv_reg;

        off_u  = off_b;
        gen_u  = gen_b;
        used_u = used_b;
        if (pos_b < POS_W'(OFFSET_DIGITS))
        begin
            off_u = (off_b << 3) + (off_b << 1) + OFFSET_W'(digit);
        end
        else if ((pos_b >= POS_W'(GEN_FIRST)) && (pos_b < POS_W'(GEN_END)))
        begin
            gen_u = (gen_b << 3) + (gen_b << 1) + GEN_W'(digit);
        end
        else if (pos_b == POS_W'(USED_POS))
        begin
            used_u = (char_in == CHAR_USED);
        end

        emit   = (pos_b >= POS_W'(ENTRY_BYTES - 1));
        in_use = used_u && (gen_u != GEN_BOGUS) && (off_u != '0);

        res0.kind         = KIND_ENTRY;
        res0.object_id    = id_ext[OBJ_ID_W-1:0];
        res0.entry_offset = off_u;
        res0.gen_or_link  = in_use ? gen_u : '0;
        res0.in_use       = in_use;
        res0.last         = in_use || !pfv_b;

        res1.kind         = KIND_PATCH;
        res1.object_id    = pfid_ext[OBJ_ID_W-1:0];
        res1.entry_offset = '0;
        res1.gen_or_link  = link_ext[GEN_W-1:0];
        res1.in_use       = 1'b0;
        res1.last         = 1'b1;

        push_cnt = '0;
        if (accept && emit)
        begin
            push_cnt = (!in_use && pfv_b) ? PUSH_W'(2) : PUSH_W'(1);
        end

        pos_next  = pos_reg;
        off_next  = off_reg;
        gen_next  = gen_reg;
        used_next = used_reg;
        id_next   = id_reg;
        pfv_next  = pfv_reg;
        pfid_next = pfid_reg;
        if (accept)
        begin
            pfv_next  = pfv_b;
            pfid_next = sub_start ? '0 : pfid_reg;
            if (emit)
            begin
                pos_next  = '0;
                off_next  = '0;
                gen_next  = '0;
                used_next = 1'b0;
                id_next   = id_b + ID_BITS'(1);
                if (!in_use)
                begin
                    pfv_next  = 1'b1;
                    pfid_next = id_b;
                end
            end
            else
            begin
                pos_next  = pos_b + POS_W'(1);
                off_next  = off_u;
                gen_next  = gen_u;
                used_next = used_u;
                id_next   = id_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            off_reg  <= '0;
            gen_reg  <= '0;
            used_reg <= 1'b0;
            id_reg   <= '0;
            pfv_reg  <= 1'b0;
            pfid_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            off_reg  <= off_next;
            gen_reg  <= gen_next;
            used_reg <= used_next;
            id_reg   <= id_next;
            pfv_reg  <= pfv_next;
            pfid_reg <= pfid_next;
        end
    end

    txp_res_fifo u_res_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .din0       (res0),
        .din1       (res1),
        .room2      (room2),
        .dout_valid (m_tvalid),
        .dout_ready (m_tready),
        .dout       (res_out)
    );

    assign m_tdata = {4'b0, res_out.in_use, res_out.gen_or_link,
                      res_out.entry_offset, res_out.object_id};
    assign m_tuser = res_out.kind;
    assign m_tlast = res_out.last;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(ENTRY_BYTES - 1))
        else $error("entry byte position out of range");

    a_entry_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> (pos_reg == '0 && off_reg == '0 && gen_reg == '0))
        else $error("entry state not cleared after last byte");

    a_patch_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == PUSH_W'(2)) |-> (!in_use && pfv_b))
        else $error("patch queued for an entry in use");

    a_free_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && !in_use) |=> (pfv_reg && pfid_reg == $past(id_b)))
        else $error("free chain not updated");

endmodule
